// ===== hdl/fqdb_pkg.sv =====
// Shared constants, types and helpers of the four-queue dispatch balancer.
package fqdb_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int COUNT_WIDTH = 32;
    localparam int QW          = (NUM_QUEUES > 2) ? $clog2(NUM_QUEUES) : 1;

    localparam int BYTES_W = 16;
    localparam int DEPTH_W = 16;
    localparam int CELL_W  = 10;
    localparam int THR_W   = 16;
    localparam int PROD_W  = DEPTH_W + CELL_W;

    localparam int DIV_STEPS = BYTES_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_ARRIVE  = 2'd0;
    localparam logic [1:0] OP_SERVICE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] MODE_SLOT   = 2'd0;
    localparam logic [1:0] MODE_RANDOM = 2'd1;
    localparam logic [1:0] MODE_SHORT  = 2'd2;
    localparam logic [1:0] MODE_CYCLIC = 2'd3;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_CELL      = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [1:0]        MODE_RESET = MODE_SLOT;
    localparam logic [CELL_W-1:0] CELL_RESET = 10'd500;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd80;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 248;

    typedef struct packed {
        logic               start;
        logic [BYTES_W-1:0] dividend;
        logic [CELL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [BYTES_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [QW-1:0] qwrap(input logic [1:0] v);
        if (32'(v) >= NUM_QUEUES) begin
            return QW'(32'(v) - NUM_QUEUES);
        end
        return QW'(v);
    endfunction

    function automatic logic [QW-1:0] qnext(input logic [QW-1:0] p);
        if (p == QW'(NUM_QUEUES - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

endpackage

// ===== hdl/fqdb_div.sv =====
// Restoring divider of packet bytes by cell size, one quotient bit per cycle.
module fqdb_div import fqdb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [BYTES_W-1:0]   num_reg, num_next;
    logic [CELL_W-1:0]    rem_reg, rem_next;
    logic [CELL_W-1:0]    dsr_reg, dsr_next;
    logic [CELL_W:0]      trial;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg, num_reg[BYTES_W-1]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            num_next  = {num_reg[BYTES_W-2:0], ge};
            rem_next  = ge ? CELL_W'(trial - {1'b0, dsr_reg}) : trial[CELL_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

// ===== hdl/four_queue_dispatch_balancer.sv =====
// Four-queue dispatch balancer: sequencer, queue state and statistics.
//
// Items enter on the s_ stream: s_tuser carries the operation (arrival,
// service, slot tick, clear statistics), s_tdata the packet size, the served
// queue and the external random pick. Each item gives exactly one result on
// the m_ stream, held in an output register until m_tready takes it.
// Configuration (mode, cell size, overflow threshold) is written through the
// cfg_ port, which is always ready; index 3 is ignored.
// An arrival of nonzero size passes from accept to result valid through start,
// 16 divider steps, quotient capture and commit, and in shortest queue mode
// first through a search that compares one queue per cycle. A service passes
// through excess, loss product and commit; a tick, a clear or a zero-byte
// arrival goes straight to commit. s_tready is high only while the sequencer
// is idle, so no new item is taken before the last has committed, though the
// sequencer may take the next item while a result still waits.
// A stalled receiver holds the sequencer at its commit step, with no state
// changed, until the output register is free.
// aresetn (synchronous, active low) zeroes depths, counters and pointers,
// loads the register reset values and empties the output register.
module four_queue_dispatch_balancer import fqdb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // packet_bytes[15:0], server_index[17:16], random_pick[19:18]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chosen_queue[1:0], cells_added[17:2], queue_depth[33:18],
    // cells_lost_now[49:34], packets_sent[81:50], bytes_sent[113:82],
    // queue_bytes_total[145:114], queue_depth_sum[177:146],
    // queue_lost_cells[209:178], queue_lost_bytes[241:210]
    output logic [M_TDATA_W-1:0] m_tdata,
    // dispatched[0], served[1]
    output logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_EXCESS = 3'd4;
    localparam logic [2:0] S_LOSS   = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    localparam int CW = COUNT_WIDTH;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [THR_W-1:0]   thr_reg;

    logic [1:0]         op_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [QW-1:0]      q_reg, q_next;
    logic [QW-1:0]      idx_reg, idx_next;
    logic [DEPTH_W-1:0] best_reg, best_next;
    logic [DEPTH_W-1:0] excess_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [BYTES_W-1:0] cells_reg;

    logic [QW-1:0]      slot_reg, cyc_reg;
    logic [CW-1:0]      arr_cnt_reg, arr_bytes_reg;

    logic [DEPTH_W-1:0] depth_reg     [NUM_QUEUES];
    logic [CW-1:0]      bytes_in_reg  [NUM_QUEUES];
    logic [CW-1:0]      depth_sum_reg [NUM_QUEUES];
    logic [CW-1:0]      lost_c_reg    [NUM_QUEUES];
    logic [CW-1:0]      lost_b_reg    [NUM_QUEUES];

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               s_acc, out_free, commit;
    logic [QW-1:0]      rd_idx;
    logic [DEPTH_W-1:0] cur_depth;
    logic [CW-1:0]      cur_bin, cur_dsum, cur_lc, cur_lb;
    logic [DEPTH_W:0]   depth_add;
    logic [DEPTH_W-1:0] n_depth;
    logic [CW-1:0]      n_bin, n_dsum, n_lc, n_lb;
    logic [CW-1:0]      n_arr_cnt, n_arr_bytes;
    logic               wr_q, clr_stats, f_disp, f_served, f_report;
    logic [BYTES_W-1:0] o_cells;
    logic [DEPTH_W-1:0] o_lost;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == S_COMMIT) && out_free;

    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = bytes_reg;
    assign div_req.divisor  = (cell_reg == '0) ? CELL_W'(1) : cell_reg;

    fqdb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign rd_idx    = (state_reg == S_SEARCH) ? idx_reg : q_reg;
    assign cur_depth = depth_reg[rd_idx];
    assign cur_bin   = bytes_in_reg[rd_idx];
    assign cur_dsum  = depth_sum_reg[rd_idx];
    assign cur_lc    = lost_c_reg[rd_idx];
    assign cur_lb    = lost_b_reg[rd_idx];

    always_comb begin
        state_next = state_reg;
        q_next     = q_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_tuser)
                        OP_ARRIVE: begin
                            if (s_tdata[BYTES_W-1:0] == '0) begin
                                state_next = S_COMMIT;
                            end else begin
                                unique case (mode_reg)
                                    MODE_SLOT:   q_next = slot_reg;
                                    MODE_RANDOM: q_next = qwrap(s_tdata[19:18]);
                                    MODE_CYCLIC: q_next = cyc_reg;
                                    default:     q_next = '0;
                                endcase
                                idx_next   = '0;
                                state_next = (mode_reg == MODE_SHORT) ? S_SEARCH : S_START;
                            end
                        end
                        OP_SERVICE: begin
                            q_next     = qwrap(s_tdata[17:16]);
                            state_next = S_EXCESS;
                        end
                        OP_TICK: begin
                            q_next     = qnext(slot_reg);
                            state_next = S_COMMIT;
                        end
                        default: begin
                            q_next     = '0;
                            state_next = S_COMMIT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (idx_reg == '0 || cur_depth <= best_reg) begin
                    q_next    = idx_reg;
                    best_next = cur_depth;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == QW'(NUM_QUEUES - 1)) begin
                    state_next = S_START;
                end
            end
            S_START:  state_next = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_COMMIT;
                end
            end
            S_EXCESS: state_next = S_LOSS;
            S_LOSS:   state_next = S_COMMIT;
            S_COMMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        depth_add   = {1'b0, cur_depth} + {1'b0, cells_reg};
        n_depth     = cur_depth;
        n_bin       = cur_bin;
        n_dsum      = cur_dsum;
        n_lc        = cur_lc;
        n_lb        = cur_lb;
        n_arr_cnt   = arr_cnt_reg;
        n_arr_bytes = arr_bytes_reg;
        wr_q        = 1'b0;
        clr_stats   = 1'b0;
        f_disp      = 1'b0;
        f_served    = 1'b0;
        f_report    = 1'b1;
        o_cells     = '0;
        o_lost      = '0;
        unique case (op_reg)
            OP_ARRIVE: begin
                n_arr_cnt   = arr_cnt_reg + CW'(1);
                n_arr_bytes = arr_bytes_reg + CW'(bytes_reg);
                if (bytes_reg != '0) begin
                    n_depth = depth_add[DEPTH_W] ? '1 : depth_add[DEPTH_W-1:0];
                    n_bin   = cur_bin + CW'(bytes_reg);
                    n_dsum  = cur_dsum + CW'(n_depth);
                    wr_q    = 1'b1;
                    f_disp  = 1'b1;
                    o_cells = cells_reg;
                end else begin
                    f_report = 1'b0;
                end
            end
            OP_SERVICE: begin
                if (cur_depth != '0) begin
                    n_depth  = cur_depth - 1'b1;
                    n_lc     = cur_lc + CW'(excess_reg);
                    n_lb     = cur_lb + CW'(prod_reg);
                    wr_q     = 1'b1;
                    f_served = 1'b1;
                    o_lost   = excess_reg;
                end
            end
            OP_TICK: begin
            end
            default: begin
                n_arr_cnt   = '0;
                n_arr_bytes = '0;
                clr_stats   = 1'b1;
                f_report    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_RESET;
            cell_reg      <= CELL_RESET;
            thr_reg       <= THR_RESET;
            slot_reg      <= '0;
            cyc_reg       <= '0;
            arr_cnt_reg   <= '0;
            arr_bytes_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                depth_reg[i]     <= '0;
                bytes_in_reg[i]  <= '0;
                depth_sum_reg[i] <= '0;
                lost_c_reg[i]    <= '0;
                lost_b_reg[i]    <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MODE:      mode_reg <= cfg_data[1:0];
                    REG_CELL:      cell_reg <= cfg_data[CELL_W-1:0];
                    REG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (commit) begin
                m_tvalid_reg  <= 1'b1;
                arr_cnt_reg   <= n_arr_cnt;
                arr_bytes_reg <= n_arr_bytes;
                if (op_reg == OP_TICK) begin
                    slot_reg <= q_reg;
                end
                if (f_disp && mode_reg == MODE_CYCLIC) begin
                    cyc_reg <= qnext(q_reg);
                end
                if (wr_q) begin
                    depth_reg[q_reg]     <= n_depth;
                    bytes_in_reg[q_reg]  <= n_bin;
                    depth_sum_reg[q_reg] <= n_dsum;
                    lost_c_reg[q_reg]    <= n_lc;
                    lost_b_reg[q_reg]    <= n_lb;
                end
                if (clr_stats) begin
                    for (int i = 0; i < NUM_QUEUES; i++) begin
                        bytes_in_reg[i]  <= '0;
                        depth_sum_reg[i] <= '0;
                    end
                end
            end
        end
        op_reg   <= s_acc ? s_tuser : op_reg;
        bytes_reg <= s_acc ? s_tdata[BYTES_W-1:0] : bytes_reg;
        q_reg    <= q_next;
        idx_reg  <= idx_next;
        best_reg <= best_next;
        if (div_rsp.done) begin
            cells_reg <= div_rsp.quotient;
        end
        if (state_reg == S_EXCESS) begin
            excess_reg <= (cur_depth > thr_reg) ? cur_depth - thr_reg : '0;
        end
        if (state_reg == S_LOSS) begin
            prod_reg <= PROD_W'(excess_reg) * PROD_W'(cell_reg);
        end
        if (commit) begin
            m_tuser_reg <= {f_served, f_disp};
            m_tdata_reg <= {6'd0,
                            f_report ? 32'(n_lb)    : 32'd0,
                            f_report ? 32'(n_lc)    : 32'd0,
                            f_report ? 32'(n_dsum)  : 32'd0,
                            f_report ? 32'(n_bin)   : 32'd0,
                            32'(n_arr_bytes),
                            32'(n_arr_cnt),
                            o_lost,
                            f_report ? n_depth : 16'd0,
                            o_cells,
                            f_report ? 2'(q_reg) : 2'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("input taken again straight after an item");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both dispatched and served");

    a_depth_covers_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[33:18] >= m_tdata[17:2]))
        else $error("queue depth below cells just added");

    a_loss_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> ({1'b0, m_tdata[49:34]} <= {1'b0, m_tdata[33:18]} + 17'd1))
        else $error("lost cells exceed the depth before service");

    a_commit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (state_reg != S_IDLE || !$past(state_reg == S_COMMIT)))
        else $error("commit while the output register was full");

endmodule

// ===== sim/four_queue_dispatch_balancer_test.sv =====
// Self-checking testbench of the four-queue dispatch balancer: directed and random streams.
module four_queue_dispatch_balancer_test import fqdb_pkg::*;;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         LONG_HOLD   = 300;

    typedef struct packed {
        logic        dispatched;
        logic        served;
        logic [1:0]  chosen_queue;
        logic [15:0] cells_added;
        logic [15:0] queue_depth;
        logic [15:0] cells_lost_now;
        logic [31:0] packets_sent;
        logic [31:0] bytes_sent;
        logic [31:0] queue_bytes_total;
        logic [31:0] queue_depth_sum;
        logic [31:0] queue_lost_cells;
        logic [31:0] queue_lost_bytes;
    } dispatch_outcome_t;

    class dispatch_scoreboard;
        logic [1:0]        mode;
        logic [9:0]        cell_size;
        logic [15:0]       thresh;
        logic [15:0]       depth [NUM_QUEUES];
        logic [31:0]       bytes_in [NUM_QUEUES];
        logic [31:0]       depth_sum [NUM_QUEUES];
        logic [31:0]       lost_cells [NUM_QUEUES];
        logic [31:0]       lost_bytes [NUM_QUEUES];
        logic [1:0]        slot_ptr;
        logic [1:0]        cyclic_ptr;
        logic [31:0]       arr_count;
        logic [31:0]       arr_bytes;
        dispatch_outcome_t awaited[$];
        int                errors;

        function new();
            mode       = MODE_RESET;
            cell_size  = CELL_RESET;
            thresh     = THR_RESET;
            slot_ptr   = '0;
            cyclic_ptr = '0;
            arr_count  = '0;
            arr_bytes  = '0;
            errors     = 0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                depth[i]      = '0;
                bytes_in[i]   = '0;
                depth_sum[i]  = '0;
                lost_cells[i] = '0;
                lost_bytes[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_MODE:      mode = val[1:0];
                REG_CELL:      cell_size = val[9:0];
                REG_THRESHOLD: thresh = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void note_item(logic [1:0] op, logic [15:0] bytes, logic [1:0] srv,
                                logic [1:0] rnd);
            dispatch_outcome_t o;
            logic [1:0]        q;
            logic              touched;
            logic [15:0]       divisor;
            logic [15:0]       cells;
            logic [15:0]       excess;
            logic [16:0]       grown;
            o       = '0;
            q       = '0;
            touched = 1'b0;
            case (op)
                OP_ARRIVE: begin
                    arr_count = arr_count + 32'd1;
                    arr_bytes = arr_bytes + 32'(bytes);
                    if (bytes != 16'd0) begin
                        divisor = (cell_size == 10'd0) ? 16'd1 : 16'(cell_size);
                        cells   = bytes / divisor;
                        case (mode)
                            MODE_SLOT:   q = slot_ptr;
                            MODE_RANDOM: q = rnd;
                            MODE_SHORT: begin
                                q = '0;
                                for (int i = 0; i < NUM_QUEUES; i++)
                                    if (depth[i] <= depth[q]) q = 2'(i);
                            end
                            default: begin
                                q          = cyclic_ptr;
                                cyclic_ptr = cyclic_ptr + 2'd1;
                            end
                        endcase
                        grown        = 17'(depth[q]) + 17'(cells);
                        depth[q]     = grown[16] ? 16'hFFFF : grown[15:0];
                        bytes_in[q]  = bytes_in[q] + 32'(bytes);
                        depth_sum[q] = depth_sum[q] + 32'(depth[q]);
                        o.dispatched  = 1'b1;
                        o.cells_added = cells;
                        touched       = 1'b1;
                    end
                end
                OP_SERVICE: begin
                    q       = srv;
                    touched = 1'b1;
                    if (depth[q] != 16'd0) begin
                        excess        = (depth[q] > thresh) ? depth[q] - thresh : 16'd0;
                        lost_cells[q] = lost_cells[q] + 32'(excess);
                        lost_bytes[q] = lost_bytes[q] + 32'(excess) * 32'(cell_size);
                        depth[q]      = depth[q] - 16'd1;
                        o.served         = 1'b1;
                        o.cells_lost_now = excess;
                    end
                end
                OP_TICK: begin
                    slot_ptr = slot_ptr + 2'd1;
                    q        = slot_ptr;
                    touched  = 1'b1;
                end
                default: begin
                    arr_count = '0;
                    arr_bytes = '0;
                    for (int i = 0; i < NUM_QUEUES; i++) begin
                        bytes_in[i]  = '0;
                        depth_sum[i] = '0;
                    end
                end
            endcase
            if (touched) begin
                o.chosen_queue      = q;
                o.queue_depth       = depth[q];
                o.queue_bytes_total = bytes_in[q];
                o.queue_depth_sum   = depth_sum[q];
                o.queue_lost_cells  = lost_cells[q];
                o.queue_lost_bytes  = lost_bytes[q];
            end
            o.packets_sent = arr_count;
            o.bytes_sent   = arr_bytes;
            awaited.push_back(o);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [1:0] user);
            dispatch_outcome_t e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                         $time, data, user);
                errors++;
                return;
            end
            e = awaited.pop_front();
            compare("dispatched", 32'(e.dispatched), 32'(user[0]));
            compare("served", 32'(e.served), 32'(user[1]));
            compare("chosen_queue", 32'(e.chosen_queue), 32'(data[1:0]));
            compare("cells_added", 32'(e.cells_added), 32'(data[17:2]));
            compare("queue_depth", 32'(e.queue_depth), 32'(data[33:18]));
            compare("cells_lost_now", 32'(e.cells_lost_now), 32'(data[49:34]));
            compare("packets_sent", e.packets_sent, data[81:50]);
            compare("bytes_sent", e.bytes_sent, data[113:82]);
            compare("queue_bytes_total", e.queue_bytes_total, data[145:114]);
            compare("queue_depth_sum", e.queue_depth_sum, data[177:146]);
            compare("queue_lost_cells", e.queue_lost_cells, data[209:178]);
            compare("queue_lost_bytes", e.queue_lost_bytes, data[241:210]);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [15:0]          cfg_data;

    bit source_gaps  = 1'b1;
    bit sink_stalls  = 1'b1;
    bit hold_request = 1'b0;
    int cycles       = 0;

    dispatch_scoreboard board = new();

    four_queue_dispatch_balancer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic offer_item(input logic [1:0] op, input logic [15:0] bytes,
                              input logic [1:0] srv, input logic [1:0] rnd);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({rnd, srv, bytes});
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, bytes, srv, rnd);
        if (source_gaps && $urandom_range(0, 99) < 40) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [9:0] cell_size,
                              input logic [15:0] thr);
        drain();
        write_reg(REG_MODE, {14'($urandom), mode});
        write_reg(REG_CELL, {6'($urandom), cell_size});
        write_reg(REG_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int count, input logic [9:0] cell_size);
        int          r;
        logic [1:0]  op;
        logic [15:0] bytes;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40)      op = OP_ARRIVE;
            else if (r < 75) op = OP_SERVICE;
            else if (r < 90) op = OP_TICK;
            else             op = OP_CLEAR;
            r = $urandom_range(0, 99);
            if (r < 8)       bytes = 16'd0;
            else if (r < 16) bytes = 16'hFFFF;
            else if (r < 56) bytes = 16'($urandom_range(0, 3 * int'(cell_size) + 2));
            else             bytes = 16'($urandom_range(0, 65535));
            offer_item(op, bytes, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [1:0]  mode;
        logic [9:0]  cell_size;
        logic [15:0] thr;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ARRIVE;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: slot round robin, 500-byte cells, threshold 80
        offer_item(OP_ARRIVE, 16'd0, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'hFFFF, 2'd0, 2'd0);
        offer_item(OP_SERVICE, 16'd0, 2'd0, 2'd0);
        offer_item(OP_SERVICE, 16'd0, 2'd2, 2'd0);
        offer_item(OP_TICK, 16'd0, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'd1000, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'd499, 2'd0, 2'd0);
        offer_item(OP_TICK, 16'd0, 2'd0, 2'd0);
        offer_item(OP_TICK, 16'd0, 2'd0, 2'd0);
        offer_item(OP_TICK, 16'd0, 2'd0, 2'd0);
        offer_item(OP_CLEAR, 16'd0, 2'd0, 2'd0);
        offer_item(OP_SERVICE, 16'd0, 2'd0, 2'd0);

        // saturate a queue; depth equal to threshold loses nothing
        set_config(MODE_RANDOM, 10'd1, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        offer_item(OP_ARRIVE, 16'hFFFF, 2'd0, 2'd3);
        offer_item(OP_ARRIVE, 16'hFFFF, 2'd0, 2'd3);
        offer_item(OP_SERVICE, 16'd0, 2'd3, 2'd0);
        offer_item(OP_ARRIVE, 16'd1, 2'd0, 2'd2);

        // zero cell size divides by one; shortest queue ties go high
        set_config(MODE_SHORT, 10'd0, 16'd0);
        offer_item(OP_SERVICE, 16'd0, 2'd3, 2'd0);
        offer_item(OP_ARRIVE, 16'd7, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'd1, 2'd0, 2'd0);

        set_config(MODE_CYCLIC, 10'd1023, 16'd5);
        offer_item(OP_ARRIVE, 16'd2046, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'd0, 2'd0, 2'd0);
        offer_item(OP_ARRIVE, 16'd1023, 2'd0, 2'd0);
        offer_item(OP_SERVICE, 16'd0, 2'd1, 2'd0);

        for (int p = 0; p < 6; p++) begin
            source_gaps = 1'b1;
            sink_stalls = 1'b1;
            case (p)
                0: begin mode = MODE_SLOT;   cell_size = 10'd1023; thr = 16'd0; end
                1: begin
                    mode      = MODE_RANDOM;
                    cell_size = 10'($urandom_range(1, 1023));
                    thr       = 16'($urandom_range(0, 300));
                end
                2: begin mode = MODE_SHORT;  cell_size = 10'd1;    thr = 16'hFFFF; end
                3: begin
                    mode      = MODE_CYCLIC;
                    cell_size = 10'd0;
                    thr       = 16'($urandom_range(0, 100));
                end
                4: begin
                    mode      = 2'($urandom_range(0, 3));
                    cell_size = 10'($urandom_range(1, 1023));
                    thr       = 16'd20;
                end
                default: begin
                    mode      = MODE_SHORT;
                    cell_size = 10'd64;
                    thr       = 16'($urandom_range(0, 65535));
                end
            endcase
            set_config(mode, cell_size, thr);
            if (p == 1) begin
                // hold the receiver while items keep coming back to back
                source_gaps  = 1'b0;
                sink_stalls  = 1'b0;
                hold_request = 1'b1;
            end else if (p == 3) begin
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            random_items(80, cell_size);
        end

        drain();
        repeat (30) @(posedge aclk);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
